### rtl/recs80_ir_frame_decoder_top_macros.svh
// ---------------------------------------------------------------------------
// RECS80 decoder assertion macros
// Shared property wrappers, clocked on clk and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef RECS80_IR_FRAME_DECODER_TOP_MACROS_SVH
`define RECS80_IR_FRAME_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define RIFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define RIFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/rifd_pkg.sv
// ---------------------------------------------------------------------------
// RECS80 decoder package
// Widths, protocol constants and the payload types shared by all modules.
// ---------------------------------------------------------------------------
package rifd_pkg;

	localparam int DURATION_W = 16;
	localparam int UNIT_W     = 10;
	localparam int TOL_W      = 7;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int BITS_W     = 11;
	localparam int POS_W      = 5;
	localparam int DEVICE_W   = 3;
	localparam int FUNC_W     = 6;
	localparam int UNITS_W    = 6;
	localparam int FAC_W      = 8;
	localparam int NOM_W      = UNIT_W + UNITS_W;
	localparam int THR_W      = NOM_W + FAC_W;
	localparam int THR_N      = 6;
	localparam int THR_IDX_W  = 3;
	localparam int D100_W     = DURATION_W + 7;
	localparam int CMP_W      = ((D100_W > THR_W) ? D100_W : THR_W) + 1;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [UNIT_W-1:0] UNIT_TIME_RESET = 10'd158;
	localparam logic [TOL_W-1:0]  TOL_RESET       = 7'd30;
	localparam logic [TOL_W-1:0]  TOL_MAX         = 7'd100;
	localparam logic [FAC_W-1:0]  PCT             = 8'd100;

	localparam logic [UNITS_W-1:0] MARK_UNITS = 6'd1;
	localparam logic [UNITS_W-1:0] ZERO_UNITS = 6'd31;
	localparam logic [UNITS_W-1:0] ONE_UNITS  = 6'd47;

	localparam logic [POS_W-1:0] START_POS    = 5'd1;
	localparam logic [POS_W-1:0] LAST_BIT_POS = 5'd21;
	localparam logic [POS_W-1:0] STOP_POS     = 5'd22;
	localparam logic [POS_W-1:0] FRAME_LEN    = 5'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UNIT_TIME = 1'b0,
		REG_TOLERANCE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [DURATION_W-1:0] duration;
		logic                  frame_end;
	} in_req_t;

	typedef struct packed {
		logic                frame_valid;
		logic [DEVICE_W-1:0] device;
		logic [FUNC_W-1:0]   function_code;
		logic                toggle;
	} out_res_t;

	// classified duration: which nominal lengths it matches
	typedef struct packed {
		logic m_mark;
		logic m_zero;
		logic m_one;
		logic frame_end;
	} cls_t;

endpackage

### rtl/rifd_front.sv
// ---------------------------------------------------------------------------
// RECS80 decoder front end
// Config registers, threshold sequencer and duration classifier.
// ---------------------------------------------------------------------------
module rifd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rifd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rifd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rifd_pkg::in_req_t             in_data,
	output logic                          push,
	output rifd_pkg::cls_t                push_data,
	input  logic                          q_full
);

	localparam int STEPS = 2 * rifd_pkg::THR_N;
	localparam int STEP_W = rifd_pkg::THR_IDX_W + 1;
	// threshold slots: low/high bound per nominal length
	localparam int THR_MARK_LO = 0;
	localparam int THR_MARK_HI = 1;
	localparam int THR_ZERO_LO = 2;
	localparam int THR_ZERO_HI = 3;
	localparam int THR_ONE_LO  = 4;
	localparam int THR_ONE_HI  = 5;

	logic [rifd_pkg::UNIT_W-1:0]  unit_time_q;
	logic [rifd_pkg::TOL_W-1:0]   tol_q;
	logic                         busy_q;
	logic [STEP_W-1:0]            step_q;
	logic [rifd_pkg::NOM_W-1:0]   nom_q;
	logic [rifd_pkg::FAC_W-1:0]   fac_q;
	logic [rifd_pkg::THR_W-1:0]   thr_q [rifd_pkg::THR_N];
	logic [rifd_pkg::TOL_W-1:0]   tol_sat;
	logic [rifd_pkg::THR_IDX_W-1:0] thr_idx;
	logic [rifd_pkg::UNITS_W-1:0] units;
	logic                         cfg_wr;
	logic                         accept;
	logic                         s1_valid_q;
	logic [rifd_pkg::D100_W-1:0]  d100_s1;
	logic                         last_s1;

	function automatic logic in_window(
		input logic [rifd_pkg::D100_W-1:0] d100,
		input logic [rifd_pkg::THR_W-1:0]  lo,
		input logic [rifd_pkg::THR_W-1:0]  hi
	);
		logic [rifd_pkg::CMP_W-1:0] dx;
		dx = rifd_pkg::CMP_W'(d100);
		// d >= floor(lo/100)  <=>  100d + 99 >= lo ; d <= floor(hi/100) <=> 100d <= hi
		return ((dx + rifd_pkg::CMP_W'(rifd_pkg::PCT - 8'd1)) >= rifd_pkg::CMP_W'(lo)) &&
			(dx <= rifd_pkg::CMP_W'(hi));
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_time_q <= rifd_pkg::UNIT_TIME_RESET;
			tol_q       <= rifd_pkg::TOL_RESET;
		end else if (cfg_wr) begin
			unique case (rifd_pkg::cfg_reg_t'(cfg_index))
				rifd_pkg::REG_UNIT_TIME: unit_time_q <= cfg_data;
				rifd_pkg::REG_TOLERANCE: tol_q <= cfg_data[rifd_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// threshold sequencer: even step forms nominal and factor, odd step multiplies
	assign tol_sat = (tol_q > rifd_pkg::TOL_MAX) ? rifd_pkg::TOL_MAX : tol_q;
	assign thr_idx = step_q[STEP_W-1:1];

	always_comb begin
		unique case (thr_idx[rifd_pkg::THR_IDX_W-1:1])
			2'd0:    units = rifd_pkg::MARK_UNITS;
			2'd1:    units = rifd_pkg::ZERO_UNITS;
			2'd2:    units = rifd_pkg::ONE_UNITS;
			default: units = rifd_pkg::MARK_UNITS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (cfg_wr) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_wr) begin
			if (!step_q[0]) begin
				nom_q <= rifd_pkg::NOM_W'(unit_time_q) * rifd_pkg::NOM_W'(units);
				fac_q <= thr_idx[0] ? (rifd_pkg::PCT + rifd_pkg::FAC_W'(tol_sat))
					: (rifd_pkg::PCT - rifd_pkg::FAC_W'(tol_sat));
			end else begin
				thr_q[thr_idx] <= rifd_pkg::THR_W'(nom_q) * rifd_pkg::THR_W'(fac_q);
			end
		end
	end

	// classifier: stage 1 holds 100*d, compare happens on the way into the queue
	assign in_stall = busy_q || (s1_valid_q && q_full);
	assign accept   = in_valid && !in_stall;
	assign push     = s1_valid_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d100_s1 <= rifd_pkg::D100_W'({in_data.duration, 6'b0})
				+ rifd_pkg::D100_W'({in_data.duration, 5'b0})
				+ rifd_pkg::D100_W'({in_data.duration, 2'b0});
			last_s1 <= in_data.frame_end;
		end
	end

	always_comb begin
		push_data.m_mark    = in_window(d100_s1, thr_q[THR_MARK_LO], thr_q[THR_MARK_HI]);
		push_data.m_zero    = in_window(d100_s1, thr_q[THR_ZERO_LO], thr_q[THR_ZERO_HI]);
		push_data.m_one     = in_window(d100_s1, thr_q[THR_ONE_LO], thr_q[THR_ONE_HI]);
		push_data.frame_end = last_s1;
	end

endmodule

### rtl/rifd_queue.sv
// ---------------------------------------------------------------------------
// RECS80 decoder queue
// Small FIFO of classified durations between front and back.
// ---------------------------------------------------------------------------
module rifd_queue #(
	parameter int DEPTH = rifd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rifd_pkg::cls_t push_data,
	output logic           full,
	input  logic           pop,
	output rifd_pkg::cls_t pop_data,
	output logic           not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rifd_pkg::cls_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/rifd_back.sv
// ---------------------------------------------------------------------------
// RECS80 decoder back end
// Frame state, bit assembly and the result register.
// ---------------------------------------------------------------------------
module rifd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  rifd_pkg::cls_t     pop_data,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output rifd_pkg::out_res_t out_data
);

	logic [rifd_pkg::POS_W-1:0]  pos_q,  pos_n;
	logic                        mark_q, mark_n;
	logic [rifd_pkg::BITS_W-1:0] bits_q, bits_n;
	logic                        err_q,  err_n;
	logic                        ovf_q,  ovf_n;
	logic                        ok;
	logic                        can_out;
	logic                        out_valid_q;
	rifd_pkg::out_res_t          out_data_q;

	assign can_out = !out_valid_q || !out_stall;
	assign pop     = not_empty && (!pop_data.frame_end || can_out);

	always_comb begin
		pos_n  = pos_q;
		mark_n = mark_q;
		bits_n = bits_q;
		err_n  = err_q;
		ovf_n  = ovf_q;
		if (pos_q >= rifd_pkg::FRAME_LEN) begin
			ovf_n = 1'b1;
		end else begin
			priority if (pos_q < rifd_pkg::STOP_POS && !pos_q[0]) begin
				mark_n = pop_data.m_mark;
			end else if (pos_q <= rifd_pkg::LAST_BIT_POS) begin
				// the one-length test wins when a space fits both
				if (!mark_q || !(pop_data.m_one || pop_data.m_zero) ||
					(pos_q == rifd_pkg::START_POS && !pop_data.m_one)) begin
					err_n = 1'b1;
				end else begin
					bits_n = {bits_q[rifd_pkg::BITS_W-2:0], pop_data.m_one};
				end
			end else if (pos_q == rifd_pkg::STOP_POS) begin
				if (!pop_data.m_mark) begin
					err_n = 1'b1;
				end
			end else begin
				// trailing duration is ignored
			end
			pos_n = pos_q + 1'b1;
		end
	end

	assign ok = !err_n && !ovf_n && (pos_n == rifd_pkg::FRAME_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mark_q <= 1'b0;
			bits_q <= '0;
			err_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (pop) begin
			if (pop_data.frame_end) begin
				pos_q  <= '0;
				mark_q <= 1'b0;
				bits_q <= '0;
				err_q  <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				pos_q  <= pos_n;
				mark_q <= mark_n;
				bits_q <= bits_n;
				err_q  <= err_n;
				ovf_q  <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && pop_data.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_data.frame_end) begin
			out_data_q.frame_valid   <= ok;
			out_data_q.device        <= ok ? bits_n[8:6] : '0;
			out_data_q.function_code <= ok ? bits_n[5:0] : '0;
			out_data_q.toggle        <= ok ? bits_n[9] : 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/recs80_ir_frame_decoder_top.sv
// ---------------------------------------------------------------------------
// RECS80 infrared frame decoder, top level
// Classifies mark/space durations and assembles 11-bit RECS80 frames.
// ---------------------------------------------------------------------------
// Usage:
//  - in channel: one duration request per in_valid/!in_stall edge, frame_end
//    set on the last duration of a capture.
//  - out channel: one result per frame_end request, held while out_stall.
//  - cfg channel: cfg_index 0 = unit_time, 1 = tolerance_pct; cfg_ready is
//    always high. Write only while no request is in flight.
//  - Throughput: one duration per cycle while in_stall is low. A result
//    reaches out_valid through the stage-1 register, the queue and the
//    result register. The threshold sequencer takes two steps per bound
//    (six bounds, one shared 16x8 multiplier) after reset and after every
//    config write; in_stall is high for that time.
//  - Reset restores unit_time 158 and tolerance 30, clears frame state and
//    the queue, and starts the threshold sequence.
//  - When out_stall holds a result, later durations still flow into the
//    queue; in_stall rises only once the queue is full and a further
//    frame_end reaches the back end.
// ---------------------------------------------------------------------------
module recs80_ir_frame_decoder_top #(
	parameter int QUEUE_DEPTH = rifd_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// duration requests
	input  logic                            in_valid,
	output logic                            in_stall,
	input  rifd_pkg::in_req_t               in_data,
	// frame results
	output logic                            out_valid,
	input  logic                            out_stall,
	output rifd_pkg::out_res_t              out_data,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rifd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rifd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// front -> queue
	logic           push;
	rifd_pkg::cls_t push_data;
	logic           q_full;
	// queue -> back
	logic           pop;
	rifd_pkg::cls_t pop_data;
	logic           q_not_empty;

	// front end: config, thresholds, classification of each duration
	rifd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// decouples classification from frame assembly
	rifd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	// back end: position tracking, bit shift, result register
	rifd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### rtl/rifd_checker.sv
// ---------------------------------------------------------------------------
// RECS80 decoder port checker
// Port-level properties, bound onto the top level.
// ---------------------------------------------------------------------------
`include "recs80_ir_frame_decoder_top_macros.svh"

module rifd_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_stall,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  rifd_pkg::out_res_t              out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready
);

	// a held result keeps its payload
	`RIFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result dropped or changed while stalled")

	// rejected frames carry zero fields
	`RIFD_ASSERT_NOW(a_invalid_zero, out_valid && !out_data.frame_valid, out_data.device == '0 && out_data.function_code == '0 && !out_data.toggle, "invalid frame with nonzero fields")

	// thresholds are rebuilt after a register write
	`RIFD_ASSERT_NEXT(a_cfg_stall, cfg_valid && cfg_ready, in_stall, "input open during threshold rebuild")

endmodule

bind recs80_ir_frame_decoder_top rifd_checker u_rifd_checker (.*);
